>>> rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, constants and types of the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int POS_W   = 6;
    localparam int SCL_W   = 24;
    localparam int SQ_W    = 2 * SCL_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int FRAC_W  = 14;
    localparam int Q_W     = FRAC_W + 1;
    localparam int NUM_W   = ROOT_W + FRAC_W + 1;
    localparam int OUT_W   = 16;
    localparam int LANES   = 3;

    // scaled magnitudes end with their top bit here
    localparam int SCL_TOP = SCL_W - 1;

    localparam logic [Q_W-1:0]    Q_ONE     = Q_W'(1 << FRAC_W);
    localparam logic [ROOT_W-1:0] ROOT_MIN  = ROOT_W'(1 << SCL_TOP);

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } ctl_t;

endpackage

>>> rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, partial products and cross product, three register stages.
// ----------------------------------------------------------------------------
module tfn_cross
    import tfn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] a_x,
    input  logic signed [COORD_W-1:0] a_y,
    input  logic signed [COORD_W-1:0] a_z,
    input  logic signed [COORD_W-1:0] b_x,
    input  logic signed [COORD_W-1:0] b_y,
    input  logic signed [COORD_W-1:0] b_z,
    input  logic signed [COORD_W-1:0] c_x,
    input  logic signed [COORD_W-1:0] c_y,
    input  logic signed [COORD_W-1:0] c_z,
    output logic                      out_valid,
    output logic signed [CROSS_W-1:0] xprod [LANES]
);

    logic [2:0] vld_reg;

    logic signed [DIFF_W-1:0]  u_reg [LANES];
    logic signed [DIFF_W-1:0]  v_reg [LANES];
    logic signed [DIFF_W-1:0]  u_next [LANES];
    logic signed [DIFF_W-1:0]  v_next [LANES];
    logic signed [PROD_W-1:0]  p_reg [2*LANES];
    logic signed [PROD_W-1:0]  p_next [2*LANES];
    logic signed [CROSS_W-1:0] c_reg [LANES];
    logic signed [CROSS_W-1:0] c_next [LANES];

    always_comb
    begin
        u_next[0] = DIFF_W'(a_x) - DIFF_W'(b_x);
        u_next[1] = DIFF_W'(a_y) - DIFF_W'(b_y);
        u_next[2] = DIFF_W'(a_z) - DIFF_W'(b_z);
        v_next[0] = DIFF_W'(a_x) - DIFF_W'(c_x);
        v_next[1] = DIFF_W'(a_y) - DIFF_W'(c_y);
        v_next[2] = DIFF_W'(a_z) - DIFF_W'(c_z);
    end

    // x = uy*vz - uz*vy, y = uz*vx - ux*vz, z = ux*vy - uy*vx
    always_comb
    begin
        p_next[0] = PROD_W'(u_reg[1]) * PROD_W'(v_reg[2]);
        p_next[1] = PROD_W'(u_reg[2]) * PROD_W'(v_reg[1]);
        p_next[2] = PROD_W'(u_reg[2]) * PROD_W'(v_reg[0]);
        p_next[3] = PROD_W'(u_reg[0]) * PROD_W'(v_reg[2]);
        p_next[4] = PROD_W'(u_reg[0]) * PROD_W'(v_reg[1]);
        p_next[5] = PROD_W'(u_reg[1]) * PROD_W'(v_reg[0]);
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            c_next[i] = CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        v_reg <= v_next;
        p_reg <= p_next;
        c_reg <= c_next;
    end

    assign out_valid = vld_reg[2];
    assign xprod     = c_reg;

endmodule

>>> rtl/tfn_norm.sv
// ----------------------------------------------------------------------------
// tfn_norm
// Magnitudes, leading-one search, scaling shift, squares and their sum.
// ----------------------------------------------------------------------------
module tfn_norm
    import tfn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [CROSS_W-1:0] xprod [LANES],
    output ctl_t                      out_ctl,
    output logic [SUM_W-1:0]          sum,
    output logic [SCL_W-1:0]          mag [LANES]
);

    // magnitude stage
    logic [MAG_W-1:0]  m4_reg [LANES];
    logic [MAG_W-1:0]  m4_next [LANES];
    logic [MAG_W-1:0]  or4_reg;
    logic [MAG_W-1:0]  or4_next;
    logic [LANES-1:0]  neg4_reg;
    logic [LANES-1:0]  neg4_next;
    logic              vld4_reg;

    // leading-one stage
    logic [MAG_W-1:0]  m5_reg [LANES];
    logic [3:0]        rsh5_reg;
    logic [3:0]        rsh5_next;
    logic [4:0]        lsh5_reg;
    logic [4:0]        lsh5_next;
    logic              right5_reg;
    logic              right5_next;
    logic [POS_W-1:0]  pos5;
    ctl_t              ctl5_reg;
    ctl_t              ctl5_next;

    // shift stage
    logic [SCL_W-1:0]  m6_reg [LANES];
    logic [SCL_W-1:0]  m6_next [LANES];
    logic [MAG_W-1:0]  wide6 [LANES];
    ctl_t              ctl6_reg;

    // square stage
    logic [SCL_W-1:0]  m7_reg [LANES];
    logic [SQ_W-1:0]   sq7_reg [LANES];
    logic [SQ_W-1:0]   sq7_next [LANES];
    ctl_t              ctl7_reg;

    // sum stage
    logic [SCL_W-1:0]  m8_reg [LANES];
    logic [SUM_W-1:0]  sum8_reg;
    logic [SUM_W-1:0]  sum8_next;
    ctl_t              ctl8_reg;

    always_comb
    begin
        or4_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            neg4_next[i] = xprod[i][CROSS_W-1];
            m4_next[i]   = xprod[i][CROSS_W-1] ? MAG_W'(-xprod[i]) : MAG_W'(xprod[i]);
            or4_next     = or4_next | m4_next[i];
        end
    end

    // the top set bit of the or is the top set bit of the largest magnitude
    always_comb
    begin
        pos5 = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (or4_reg[i])
            begin
                pos5 = POS_W'(i);
            end
        end
        right5_next     = (pos5 >= POS_W'(SCL_TOP));
        rsh5_next       = 4'(pos5 - POS_W'(SCL_TOP));
        lsh5_next       = 5'(POS_W'(SCL_TOP) - pos5);
        ctl5_next.valid = vld4_reg;
        ctl5_next.zero  = (or4_reg == '0);
        ctl5_next.neg   = neg4_reg;
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            wide6[i]   = right5_reg ? (m5_reg[i] >> rsh5_reg) : (m5_reg[i] << lsh5_reg);
            m6_next[i] = wide6[i][SCL_W-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sq7_next[i] = SQ_W'(m6_reg[i]) * SQ_W'(m6_reg[i]);
        end
    end

    always_comb
    begin
        sum8_next = SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
            ctl8_reg <= '0;
        end
        else
        begin
            vld4_reg <= in_valid;
            ctl5_reg <= ctl5_next;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
            ctl8_reg <= ctl7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m4_reg     <= m4_next;
        or4_reg    <= or4_next;
        neg4_reg   <= neg4_next;
        m5_reg     <= m4_reg;
        rsh5_reg   <= rsh5_next;
        lsh5_reg   <= lsh5_next;
        right5_reg <= right5_next;
        m6_reg     <= m6_next;
        m7_reg     <= m6_reg;
        sq7_reg    <= sq7_next;
        m8_reg     <= m7_reg;
        sum8_reg   <= sum8_next;
    end

    assign out_ctl = ctl8_reg;
    assign sum     = sum8_reg;
    assign mag     = m8_reg;

    // after scaling the largest magnitude has its top bit exactly at the top
    a_scaled_top: assert property (@(posedge clk) disable iff (!rst_n)
        ctl6_reg.valid && !ctl6_reg.zero |->
            ((m6_reg[0] | m6_reg[1] | m6_reg[2]) >> SCL_TOP) == SCL_W'(1))
        else $error("scaled magnitudes not normalized");

endmodule

>>> rtl/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              in_ctl,
    input  logic [SUM_W-1:0]  rad,
    input  logic [SCL_W-1:0]  in_mag [LANES],
    output ctl_t              out_ctl,
    output logic [ROOT_W-1:0] root,
    output logic [SCL_W-1:0]  out_mag [LANES]
);

    ctl_t              ctl_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    logic [SCL_W-1:0]  mag_reg  [ROOT_W][LANES];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        ctl_t              ctl_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rad_in;
        logic [SCL_W-1:0]  mag_in [LANES];
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign ctl_in  = in_ctl;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign mag_in  = in_mag;
        end
        else
        begin : g_next
            assign ctl_in  = ctl_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign mag_in  = mag_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in, rad_in[SUM_W-1-2*k -: 2]};
            trial = (REM_W+2)'({root_in, 2'b01});
            if (cur >= trial)
            begin
                rem_next  = REM_W'(cur - trial);
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(cur);
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            rad_reg[k]  <= rad_in;
            mag_reg[k]  <= mag_in;
        end
    end

    assign out_ctl = ctl_reg[ROOT_W-1];
    assign root    = root_reg[ROOT_W-1];
    assign out_mag = mag_reg[ROOT_W-1];

    // a normalized vector has length at least the scaled top bit
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.valid && !out_ctl.zero |-> root >= ROOT_MIN)
        else $error("square root below normalized range");

endmodule

>>> rtl/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// One lane of the pipelined restoring divider, one quotient bit per stage,
// giving the rounded Q1.14 ratio of a magnitude to the vector length.
// ----------------------------------------------------------------------------
module tfn_div
    import tfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              in_ctl,
    input  logic [SCL_W-1:0]  m,
    input  logic [ROOT_W-1:0] len,
    output ctl_t              out_ctl,
    output logic [Q_W-1:0]    q
);

    ctl_t              ctl0_reg;
    logic [NUM_W-1:0]  num0_reg;
    logic [NUM_W-1:0]  num0_next;
    logic [ROOT_W-1:0] den0_reg;

    ctl_t              ctl_reg [Q_W];
    logic [NUM_W-1:0]  rem_reg [Q_W];
    logic [ROOT_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]    q_reg   [Q_W];

    // rounding to nearest: add half the divisor
    always_comb
    begin
        num0_next = NUM_W'({m, FRAC_W'(0)}) + NUM_W'(len >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        num0_reg <= num0_next;
        den0_reg <= len;
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        ctl_t              ctl_in;
        logic [NUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [Q_W-1:0]    q_in;
        logic [NUM_W-1:0]  sub;
        logic [NUM_W-1:0]  rem_next;
        logic [Q_W-1:0]    q_next;

        if (k == 0)
        begin : g_first
            assign ctl_in = ctl0_reg;
            assign rem_in = num0_reg;
            assign den_in = den0_reg;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign ctl_in = ctl_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            sub      = NUM_W'(den_in) << (Q_W - 1 - k);
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= sub)
            begin
                rem_next            = rem_in - sub;
                q_next[Q_W - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_in;
            q_reg[k]   <= q_next;
        end
    end

    assign out_ctl = ctl_reg[Q_W-1];
    assign q       = q_reg[Q_W-1];

endmodule

>>> rtl/triangle_face_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle: cross product of its edges, scaled to a
// Q1.14 unit vector, with a flag for triangles that have no direction.
// ----------------------------------------------------------------------------
// A triangle is taken in every clock cycle in which start is high; busy stays
// low, so the block never refuses a transfer. Each triangle gives one result,
// shown for one cycle with done high, in the order the triangles came in; the
// receiver cannot stall the block. A triangle passes through the three cross
// product stages, five scaling stages, the 25-stage square root, the 16-stage
// divider and a final output register.
module triangle_face_normal_core
    import tfn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] a_x,
    input  logic signed [COORD_W-1:0] a_y,
    input  logic signed [COORD_W-1:0] a_z,
    input  logic signed [COORD_W-1:0] b_x,
    input  logic signed [COORD_W-1:0] b_y,
    input  logic signed [COORD_W-1:0] b_z,
    input  logic signed [COORD_W-1:0] c_x,
    input  logic signed [COORD_W-1:0] c_y,
    input  logic signed [COORD_W-1:0] c_z,
    output logic                      done,
    output logic signed [OUT_W-1:0]   norm_x,
    output logic signed [OUT_W-1:0]   norm_y,
    output logic signed [OUT_W-1:0]   norm_z,
    output logic                      degenerate
);

    logic                      cross_valid;
    logic signed [CROSS_W-1:0] xprod [LANES];
    ctl_t                      norm_ctl;
    logic [SUM_W-1:0]          sum;
    logic [SCL_W-1:0]          scl_mag [LANES];
    ctl_t                      sqrt_ctl;
    logic [ROOT_W-1:0]         root;
    logic [SCL_W-1:0]          root_mag [LANES];
    ctl_t                      div_ctl [LANES];
    logic [Q_W-1:0]            quo [LANES];

    logic                      done_reg;
    logic                      degen_reg;
    logic [OUT_W-1:0]          comp_reg  [LANES];
    logic [OUT_W-1:0]          comp_next [LANES];
    logic [Q_W-1:0]            qsat [LANES];

    assign busy = 1'b0;

    tfn_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .out_valid (cross_valid),
        .xprod     (xprod)
    );

    tfn_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cross_valid),
        .xprod    (xprod),
        .out_ctl  (norm_ctl),
        .sum      (sum),
        .mag      (scl_mag)
    );

    tfn_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (norm_ctl),
        .rad     (sum),
        .in_mag  (scl_mag),
        .out_ctl (sqrt_ctl),
        .root    (root),
        .out_mag (root_mag)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        tfn_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (sqrt_ctl),
            .m       (root_mag[i]),
            .len     (root),
            .out_ctl (div_ctl[i]),
            .q       (quo[i])
        );
    end

    // saturate, apply sign, force zero for a degenerate triangle
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            qsat[i] = (quo[i] > Q_ONE) ? Q_ONE : quo[i];
            if (div_ctl[0].zero)
            begin
                comp_next[i] = '0;
            end
            else if (div_ctl[0].neg[i])
            begin
                comp_next[i] = OUT_W'(-OUT_W'(qsat[i]));
            end
            else
            begin
                comp_next[i] = OUT_W'(qsat[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_ctl[0].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degen_reg <= div_ctl[0].zero;
        comp_reg  <= comp_next;
    end

    assign done       = done_reg;
    assign degenerate = degen_reg;
    assign norm_x     = comp_reg[0];
    assign norm_y     = comp_reg[1];
    assign norm_z     = comp_reg[2];

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl[1] == div_ctl[0] && div_ctl[2] == div_ctl[0])
        else $error("divider lanes out of step");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
        else $error("degenerate transfer with nonzero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |->
            norm_x <= $signed(OUT_W'(Q_ONE)) && norm_x >= -$signed(OUT_W'(Q_ONE)) &&
            norm_y <= $signed(OUT_W'(Q_ONE)) && norm_y >= -$signed(OUT_W'(Q_ONE)) &&
            norm_z <= $signed(OUT_W'(Q_ONE)) && norm_z >= -$signed(OUT_W'(Q_ONE)) &&
            (norm_x != '0 || norm_y != '0 || norm_z != '0))
        else $error("normal component out of unit range");

endmodule
